>>> rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and status codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int BLOCKS_DEF   = 64;
    localparam int PID_BITS_DEF = 8;

    localparam int PID_W    = 8;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;
    localparam int START_W  = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_DUP     = 3'd1;
    localparam status_t ST_NOSPACE = 3'd2;
    localparam status_t ST_FRAG    = 3'd3;
    localparam status_t ST_INVALID = 3'd4;

endpackage

>>> rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Owner-tag memory with a sequential first-fit scan and run tagging.
// ----------------------------------------------------------------------------
// channel  dir  signals                    contents
// s_*      in   tvalid tready tdata[15:0]  pid, block_count
// m_*      out  tvalid tready tdata[15:0]  status, start_block
//
// After reset a clearing pass writes every owner entry to zero, with s_tready
// low meanwhile.
// Invalid request: skips the scan and goes straight to the final load step.
// Otherwise: a scan through the single read port of the owner memory (a read
// of every entry, then a drain step for the read latency), a decide step, one
// write per block when allocated, then the final load of the result.
// One request in flight at a time.
// A result waiting on m_tready holds the block only at the final load step.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int BLOCKS   = ffba_pkg::BLOCKS_DEF,
    parameter int PID_BITS = ffba_pkg::PID_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ffba_pkg::IN_DATA_W-1:0]    s_tdata,   // pid[7:0], block_count[14:8]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ffba_pkg::OUT_DATA_W-1:0]   m_tdata    // status[2:0], start_block[8:3]
);

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W = $clog2(BLOCKS + 1);
    localparam int CMP_W = (CNT_W > ffba_pkg::COUNT_W) ? CNT_W : ffba_pkg::COUNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCKS - 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0]               addr_reg, addr_next;
    logic [PID_BITS-1:0]            pid_reg, pid_next;
    logic [ffba_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [ffba_pkg::COUNT_W-1:0]   left_reg, left_next;
    logic                           rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]               rd_idx_reg, rd_idx_next;
    logic                           dup_reg, dup_next;
    logic [CNT_W-1:0]               free_reg, free_next;
    logic [CNT_W-1:0]               run_reg, run_next;
    logic                           found_reg, found_next;
    logic [IDX_W-1:0]               start_reg, start_next;
    ffba_pkg::status_t              res_status_reg, res_status_next;
    logic [ffba_pkg::START_W-1:0]   res_start_reg, res_start_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    ffba_pkg::status_t              out_status_reg, out_status_next;
    logic [ffba_pkg::START_W-1:0]   out_start_reg, out_start_next;

    logic [PID_BITS-1:0] owner_mem [BLOCKS];
    logic [PID_BITS-1:0] rd_data_reg;
    logic                rd_en;
    logic                wr_en;
    logic [PID_BITS-1:0] wr_data;

    logic [ffba_pkg::PID_W-1:0]   in_pid;
    logic [ffba_pkg::COUNT_W-1:0] in_count;
    logic [PID_BITS-1:0]          in_pid_m;
    logic                         is_free;
    logic [CMP_W-1:0]             run_inc;
    logic                         s_accept;

    assign in_pid   = s_tdata[7:0];
    assign in_count = s_tdata[14:8];
    assign in_pid_m = PID_BITS'(in_pid);

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_start_reg, out_status_reg};

    assign rd_en   = (state_reg == S_SCAN);
    assign wr_en   = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign wr_data = (state_reg == S_CLEAR) ? '0 : pid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_mem[addr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= owner_mem[addr_reg];
        end
    end

    assign is_free = (rd_data_reg == '0);
    assign run_inc = CMP_W'(run_reg) + CMP_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        pid_next        = pid_reg;
        count_next      = count_reg;
        left_next       = left_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        dup_next        = dup_reg;
        free_next       = free_reg;
        run_next        = run_reg;
        found_next      = found_reg;
        start_next      = start_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // scan accumulation, one owner word per cycle
        if (rd_pend_reg)
        begin
            if (rd_data_reg == pid_reg)
            begin
                dup_next = 1'b1;
            end
            if (is_free)
            begin
                free_next = free_reg + CNT_W'(1);
                run_next  = CNT_W'(run_inc);
                if (!found_reg && (run_inc == CMP_W'(count_reg)))
                begin
                    found_next = 1'b1;
                    start_next = rd_idx_reg - IDX_W'(count_reg - 7'd1);
                end
            end
            else
            begin
                run_next = '0;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                addr_next = addr_reg + IDX_W'(1);
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_accept)
                begin
                    pid_next   = in_pid_m;
                    count_next = in_count;
                    dup_next   = 1'b0;
                    free_next  = '0;
                    run_next   = '0;
                    found_next = 1'b0;
                    addr_next  = '0;
                    if ((in_pid_m == '0) || (in_count == '0))
                    begin
                        res_status_next = ffba_pkg::ST_INVALID;
                        res_start_next  = '0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_pend_next = 1'b1;
                rd_idx_next  = addr_reg;
                addr_next    = addr_reg + IDX_W'(1);
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                res_start_next = '0;
                state_next     = S_FIN;
                if (dup_reg)
                begin
                    res_status_next = ffba_pkg::ST_DUP;
                end
                else if (CMP_W'(free_reg) < CMP_W'(count_reg))
                begin
                    res_status_next = ffba_pkg::ST_NOSPACE;
                end
                else if (found_reg)
                begin
                    res_status_next = ffba_pkg::ST_OK;
                    res_start_next  = ffba_pkg::START_W'(start_reg);
                    addr_next       = start_reg;
                    left_next       = count_reg;
                    state_next      = S_WRITE;
                end
                else
                begin
                    res_status_next = ffba_pkg::ST_FRAG;
                end
            end
            S_WRITE:
            begin
                addr_next = addr_reg + IDX_W'(1);
                left_next = left_reg - 7'd1;
                if (left_reg == 7'd1)
                begin
                    addr_next  = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            addr_reg       <= '0;
            pid_reg        <= '0;
            count_reg      <= '0;
            left_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            dup_reg        <= 1'b0;
            free_reg       <= '0;
            run_reg        <= '0;
            found_reg      <= 1'b0;
            start_reg      <= '0;
            res_status_reg <= ffba_pkg::ST_OK;
            res_start_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            out_status_reg <= ffba_pkg::ST_OK;
            out_start_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            pid_reg        <= pid_next;
            count_reg      <= count_next;
            left_reg       <= left_next;
            rd_pend_reg    <= rd_pend_next;
            rd_idx_reg     <= rd_idx_next;
            dup_reg        <= dup_next;
            free_reg       <= free_next;
            run_reg        <= run_next;
            found_reg      <= found_next;
            start_reg      <= start_next;
            res_status_reg <= res_status_next;
            res_start_reg  <= res_start_next;
            m_tvalid_reg   <= m_tvalid_next;
            out_status_reg <= out_status_next;
            out_start_reg  <= out_start_next;
        end
    end

endmodule

>>> rtl/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the first-fit block allocator.
// ----------------------------------------------------------------------------
module ffba_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ffba_pkg::OUT_DATA_W-1:0]   m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == ffba_pkg::ST_OK) || (m_tdata[2:0] == ffba_pkg::ST_DUP)
            || (m_tdata[2:0] == ffba_pkg::ST_NOSPACE) || (m_tdata[2:0] == ffba_pkg::ST_FRAG)
            || (m_tdata[2:0] == ffba_pkg::ST_INVALID))
        else $error("status out of range");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ffba_pkg::ST_OK) |-> (m_tdata[8:3] == 6'd0))
        else $error("start_block nonzero on failed request");

    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one in flight");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/tb_first_fit_block_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Sends pid/block_count requests to the allocator and compares every returned
// status and start block with a first-fit scan over a local copy of the
// owner tags. Covers invalid and oversized requests, duplicate ids and a long
// random run with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;

    localparam int NBLOCKS     = ffba_pkg::BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN       = 2 * NBLOCKS + 16;

    typedef struct packed {
        logic [ffba_pkg::COUNT_W-1:0] block_count;
        logic [ffba_pkg::PID_W-1:0]   pid;
    } alloc_req_t;

    typedef struct packed {
        logic [ffba_pkg::START_W-1:0] start_block;
        ffba_pkg::status_t            status;
    } alloc_res_t;

    logic                            clk;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ffba_pkg::IN_DATA_W-1:0]  s_tdata  = '0;   // pid[7:0], block_count[14:8]
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ffba_pkg::OUT_DATA_W-1:0] m_tdata;         // status[2:0], start_block[8:3]

    logic [ffba_pkg::PID_W-1:0] owner_tag [NBLOCKS];
    alloc_res_t       alloc_outcomes_q [$];
    int               mismatches = 0;
    int               cycles     = 0;
    bit               no_idle    = 1'b0;

    first_fit_block_allocator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic alloc_res_t first_fit_allocate(input alloc_req_t req);
        alloc_res_t res;
        int         free_n;
        int         run;
        int         first;
        bit         dup;
        bit         done;
        res    = '0;
        free_n = 0;
        run    = 0;
        dup    = 1'b0;
        done   = 1'b0;
        if (req.pid == '0 || req.block_count == '0)
        begin
            res.status = ffba_pkg::ST_INVALID;
            return res;
        end
        for (int i = 0; i < NBLOCKS; i++)
        begin
            if (owner_tag[i] == req.pid)
                dup = 1'b1;
            if (owner_tag[i] == '0)
                free_n++;
        end
        if (dup)
        begin
            res.status = ffba_pkg::ST_DUP;
            return res;
        end
        if (free_n < int'(req.block_count))
        begin
            res.status = ffba_pkg::ST_NOSPACE;
            return res;
        end
        for (int i = 0; i < NBLOCKS && !done; i++)
        begin
            run = (owner_tag[i] == '0) ? run + 1 : 0;
            if (run == int'(req.block_count))
            begin
                first = i + 1 - run;
                for (int j = first; j <= i; j++)
                    owner_tag[j] = req.pid;
                res.status      = ffba_pkg::ST_OK;
                res.start_block = ffba_pkg::START_W'(first);
                done            = 1'b1;
            end
        end
        if (!done)
            res.status = ffba_pkg::ST_FRAG;
        return res;
    endfunction

    // result stream: random backpressure, compare each accepted result
    always @(posedge clk)
    begin
        alloc_res_t got;
        alloc_res_t want;
        if (m_tvalid && m_tready)
        begin
            got = alloc_res_t'(m_tdata[ffba_pkg::STATUS_W+ffba_pkg::START_W-1:0]);
            if (alloc_outcomes_q.size() == 0)
            begin
                $error("unexpected result: status %0d start_block %0d",
                       got.status, got.start_block);
                mismatches++;
            end
            else
            begin
                want = alloc_outcomes_q.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.start_block !== want.start_block)
                begin
                    $error("start_block: expected %0d, actual %0d",
                           want.start_block, got.start_block);
                    mismatches++;
                end
            end
        end
        if (rst_n)
            m_tready <= no_idle || ($urandom_range(0, 99) >= 13);
    end

    task automatic send_request(input logic [ffba_pkg::PID_W-1:0] pid,
                                input logic [ffba_pkg::COUNT_W-1:0] block_count);
        alloc_req_t req;
        bit         ready_seen;
        req.pid         = pid;
        req.block_count = block_count;
        while (!no_idle && $urandom_range(0, 99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ffba_pkg::IN_DATA_W'(req);
        // s_tready only moves at rising edges, so mid-cycle shows the edge value
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        alloc_outcomes_q.push_back(first_fit_allocate(req));
    endtask

    task automatic test_invalid();
        send_request(8'd0, 7'd5);
        send_request(8'd7, 7'd0);
        send_request(8'd0, 7'd0);
        send_request(8'd255, 7'd0);
        send_request(8'd0, 7'd127);
    endtask

    task automatic test_oversized();
        send_request(8'd9, 7'd65);
        send_request(8'd255, 7'd127);
        send_request(8'd170, 7'd96);
    endtask

    task automatic test_first_fit();
        send_request(8'd255, 7'd1);
        send_request(8'd1, 7'd3);
        send_request(8'd128, 7'd2);
        // full-size request once memory is partly used
        send_request(8'd64, 7'd64);
        send_request(8'd255, 7'd1);
        send_request(8'd1, 7'd20);
        send_request(8'd85, 7'd42);
        send_request(8'd42, 7'd21);
        send_request(8'd42, 7'd1);
    endtask

    task automatic test_random(input int n);
        logic [ffba_pkg::PID_W-1:0]   pid;
        logic [ffba_pkg::COUNT_W-1:0] cnt;
        int                           sel;
        for (int k = 0; k < n; k++)
        begin
            no_idle = (k >= n / 4) && (k < n / 2);
            pid = (($urandom_range(0, 99) < 5) ? 8'd0
                   : ffba_pkg::PID_W'($urandom_range(1, 255)));
            sel = $urandom_range(0, 99);
            if (sel < 60)
                cnt = ffba_pkg::COUNT_W'($urandom_range(1, 2));
            else if (sel < 85)
                cnt = ffba_pkg::COUNT_W'($urandom_range(1, 8));
            else if (sel < 90)
                cnt = '0;
            else
                cnt = ffba_pkg::COUNT_W'($urandom_range(9, 127));
            send_request(pid, cnt);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < NBLOCKS; i++)
            owner_tag[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_invalid();
        test_oversized();
        test_first_fit();
        test_random(780);
        s_tvalid <= 1'b0;
        while (alloc_outcomes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/ffba_pkg.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_checker.sv
test/tb_first_fit_block_allocator.sv
